// File: hw/rtl/rlwq_pkg.sv
// ----------------------------------------------------------------------------
// rlwq_pkg
// Shared types and defaults for the recursive lock with its queue of waiters.
// ----------------------------------------------------------------------------
package rlwq_pkg;

  localparam int DEF_MAX_THREADS = 16;
  localparam int DEF_MAX_NEST    = 255;

  localparam int TID_W    = 4;
  localparam int STATUS_W = 4;
  localparam int NEST_O_W = 8;
  localparam int QLEN_W   = 5;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED         = 4'd0,
    ST_NESTED_GRANT    = 4'd1,
    ST_QUEUED          = 4'd2,
    ST_NESTED_RELEASE  = 4'd3,
    ST_FREED           = 4'd4,
    ST_HANDED_OFF      = 4'd5,
    ST_NOT_HOLDER      = 4'd6,
    ST_ALREADY_WAITING = 4'd7,
    ST_NEST_SATURATED  = 4'd8
  } status_t;

  typedef struct packed {
    op_t              opcode;
    logic [TID_W-1:0] thread_id;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic                woken_valid;
    logic [TID_W-1:0]    woken_thread;
    logic [NEST_O_W-1:0] nest_count;
    logic [QLEN_W-1:0]   queue_length;
  } rsp_t;

endpackage

// File: hw/rtl/rlwq_core.sv
// ----------------------------------------------------------------------------
// rlwq_core
// Lock state, waiter fifo and waiting bitmap; resolves one request a cycle while accept is high.
// ----------------------------------------------------------------------------
module rlwq_core #(
  parameter int MAX_THREADS = rlwq_pkg::DEF_MAX_THREADS,
  parameter int MAX_NEST    = rlwq_pkg::DEF_MAX_NEST
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  rlwq_pkg::req_t req,
  output rlwq_pkg::rsp_t rsp
);

  localparam int IDX_W  = (MAX_THREADS > 2) ? $clog2(MAX_THREADS) : 1;
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);
  localparam int SUM_W  = IDX_W + 1;
  localparam int NEST_W = (MAX_NEST > 1) ? $clog2(MAX_NEST + 1) : 1;
  localparam int TID_W  = rlwq_pkg::TID_W;

  logic                   held, held_next;
  logic [TID_W-1:0]       owner, owner_next;
  logic [NEST_W-1:0]      nesting, nesting_next;
  logic [IDX_W-1:0]       head, head_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [MAX_THREADS-1:0] waiting_map;
  logic [TID_W-1:0]       wait_fifo [MAX_THREADS];
  logic [TID_W-1:0]       head_entry;

  logic                   tid_ok;
  logic                   is_owner;
  logic [IDX_W-1:0]       tid_idx;
  logic [IDX_W-1:0]       woke_idx;
  logic [SUM_W-1:0]       tail_sum;
  logic [IDX_W-1:0]       tail;
  logic [IDX_W-1:0]       head_inc;
  logic                   wr_en;
  logic                   set_wait;
  logic                   clr_wait;
  rlwq_pkg::status_t      status;
  logic                   woken_valid;
  logic [TID_W-1:0]       woken_thread;

  assign tid_ok   = 32'(req.thread_id) < MAX_THREADS;
  assign is_owner = held && (owner == req.thread_id);
  assign tid_idx  = IDX_W'(req.thread_id);
  assign woke_idx = IDX_W'(head_entry);

  // tail = head + count, wrapped at the fifo depth
  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign tail     = (32'(tail_sum) >= MAX_THREADS) ?
                    IDX_W'(tail_sum - SUM_W'(MAX_THREADS)) : IDX_W'(tail_sum);
  assign head_inc = (32'(head) == MAX_THREADS - 1) ? '0 : head + 1'b1;

  always_comb begin
    held_next    = held;
    owner_next   = owner;
    nesting_next = nesting;
    head_next    = head;
    count_next   = count;
    wr_en        = 1'b0;
    set_wait     = 1'b0;
    clr_wait     = 1'b0;
    woken_valid  = 1'b0;
    woken_thread = '0;
    status       = rlwq_pkg::ST_NOT_HOLDER;
    if (tid_ok) begin
      unique case (req.opcode)
        rlwq_pkg::OP_ACQUIRE: begin
          if (is_owner) begin
            if (32'(nesting) >= MAX_NEST) begin
              status = rlwq_pkg::ST_NEST_SATURATED;
            end else begin
              nesting_next = nesting + 1'b1;
              status       = rlwq_pkg::ST_NESTED_GRANT;
            end
          end else if (!held) begin
            held_next    = 1'b1;
            owner_next   = req.thread_id;
            nesting_next = NEST_W'(1);
            status       = rlwq_pkg::ST_GRANTED;
          end else if (waiting_map[tid_idx] || 32'(count) >= MAX_THREADS) begin
            status = rlwq_pkg::ST_ALREADY_WAITING;
          end else begin
            wr_en      = 1'b1;
            set_wait   = 1'b1;
            count_next = count + 1'b1;
            status     = rlwq_pkg::ST_QUEUED;
          end
        end
        rlwq_pkg::OP_RELEASE: begin
          if (!is_owner) begin
            status = rlwq_pkg::ST_NOT_HOLDER;
          end else if (32'(nesting) > 1) begin
            nesting_next = nesting - 1'b1;
            status       = rlwq_pkg::ST_NESTED_RELEASE;
          end else if (count != '0) begin
            head_next    = head_inc;
            count_next   = count - 1'b1;
            clr_wait     = 1'b1;
            owner_next   = head_entry;
            nesting_next = NEST_W'(1);
            woken_valid  = 1'b1;
            woken_thread = head_entry;
            status       = rlwq_pkg::ST_HANDED_OFF;
          end else begin
            held_next    = 1'b0;
            owner_next   = '0;
            nesting_next = '0;
            status       = rlwq_pkg::ST_FREED;
          end
        end
        default: status = rlwq_pkg::ST_NOT_HOLDER;
      endcase
    end
  end

  always_comb begin
    rsp.status       = status;
    rsp.woken_valid  = woken_valid;
    rsp.woken_thread = woken_thread;
    rsp.nest_count   = held_next ? rlwq_pkg::NEST_O_W'(nesting_next) : '0;
    rsp.queue_length = rlwq_pkg::QLEN_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= 1'b0;
      owner       <= '0;
      nesting     <= '0;
      head        <= '0;
      count       <= '0;
      waiting_map <= '0;
    end else if (accept) begin
      held    <= held_next;
      owner   <= owner_next;
      nesting <= nesting_next;
      head    <= head_next;
      count   <= count_next;
      if (set_wait) begin
        waiting_map[tid_idx] <= 1'b1;
      end
      if (clr_wait) begin
        waiting_map[woke_idx] <= 1'b0;
      end
    end
  end

  // waiter fifo; head_entry always holds the entry at the head for next cycle
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      wait_fifo[tail] <= req.thread_id;
    end
    if (accept && wr_en && (tail == head_next)) begin
      head_entry <= req.thread_id;
    end else begin
      head_entry <= wait_fifo[accept ? head_next : head];
    end
  end

endmodule

// File: hw/rtl/recursive_lock_with_wait_queue.sv
// ----------------------------------------------------------------------------
// recursive_lock_with_wait_queue
// Reentrant lock arbiter with a first-in first-out queue of waiting threads.
// ----------------------------------------------------------------------------
// Takes one acquire or release item per cycle while req_stall is low and
// returns one result item for each, in order, from the registered output. The
// request is resolved in a single pass against the lock registers, the waiting
// bitmap and a prefetched copy of the fifo head, so a new item can enter every
// cycle that req_stall is low. A registered output and a one-deep skid stage
// let the block take an item while a result is stalled; req_stall rises only
// when both hold a result. State is cleared by reset; the waiter fifo needs no
// clearing since only queued entries are ever read.
module recursive_lock_with_wait_queue #(
  parameter int MAX_THREADS = rlwq_pkg::DEF_MAX_THREADS,
  parameter int MAX_NEST    = rlwq_pkg::DEF_MAX_NEST
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rlwq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rlwq_pkg::rsp_t rsp
);

  logic           accept;
  logic           taken;
  logic           skid_valid;
  rlwq_pkg::rsp_t skid;
  rlwq_pkg::rsp_t result;

  assign req_stall = skid_valid;
  assign accept    = req_valid && !skid_valid;
  assign taken     = rsp_valid && !rsp_stall;

  rlwq_core #(
    .MAX_THREADS(MAX_THREADS),
    .MAX_NEST   (MAX_NEST)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .req   (req),
    .rsp   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (taken) begin
      if (skid_valid) begin
        rsp        <= skid;
        skid_valid <= 1'b0;
      end else if (accept) begin
        rsp <= result;
      end else begin
        rsp_valid <= 1'b0;
      end
    end else if (rsp_valid) begin
      // output stalled: park the new item in the skid stage
      if (accept) begin
        skid       <= result;
        skid_valid <= 1'b1;
      end
    end else if (accept) begin
      rsp       <= result;
      rsp_valid <= 1'b1;
    end
  end

endmodule

// File: verif/recursive_lock_with_wait_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recursive_lock_with_wait_queue_checker
// Watches both channels of the lock arbiter, keeps its own copy of the lock,
// nest count and waiter ring, and compares every result item in order.
// ----------------------------------------------------------------------------
module recursive_lock_with_wait_queue_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  logic                     req_stall,
  input  rlwq_pkg::req_t           req,
  input  logic                     rsp_valid,
  input  logic                     rsp_stall,
  input  rlwq_pkg::rsp_t           rsp,
  output int                       fail_count,
  output int                       pending,
  output int                       checked,
  output int                       handoffs,
  output int                       saturations,
  output int                       peak_waiters
);

  localparam int NUM_THREADS = rlwq_pkg::DEF_MAX_THREADS;
  localparam int NEST_LIMIT  = rlwq_pkg::DEF_MAX_NEST;

  // shadow of the lock
  logic                       lock_held;
  logic [rlwq_pkg::TID_W-1:0] lock_owner;
  int                         lock_depth;
  logic [rlwq_pkg::TID_W-1:0] waiter_ring [NUM_THREADS];
  int                         ring_head;
  int                         ring_count;
  logic                       is_waiting [NUM_THREADS];

  rlwq_pkg::rsp_t expected_rsp_q [$];
  rlwq_pkg::rsp_t want;
  rlwq_pkg::rsp_t predicted;
  int   n_fail;
  int   n_checked;
  int   n_handoffs;
  int   n_saturated;
  int   n_peak;

  initial begin
    n_fail      = 0;
    n_checked   = 0;
    n_handoffs  = 0;
    n_saturated = 0;
    n_peak      = 0;
  end

  task automatic clear_lock();
    lock_held  = 1'b0;
    lock_owner = '0;
    lock_depth = 0;
    ring_head  = 0;
    ring_count = 0;
    for (int i = 0; i < NUM_THREADS; i++) begin
      waiter_ring[i] = '0;
      is_waiting[i]  = 1'b0;
    end
  endtask

  // applies one request to the shadow lock and returns the result it owes
  task automatic resolve_request(input rlwq_pkg::req_t r, output rlwq_pkg::rsp_t e);
    rlwq_pkg::status_t          st;
    logic                       woke;
    logic [rlwq_pkg::TID_W-1:0] woken;
    logic [rlwq_pkg::TID_W-1:0] tid;
    st    = rlwq_pkg::ST_NOT_HOLDER;
    woke  = 1'b0;
    woken = '0;
    tid   = r.thread_id;
    if (r.opcode == rlwq_pkg::OP_ACQUIRE) begin
      if (lock_held && lock_owner == tid) begin
        if (lock_depth >= NEST_LIMIT) begin
          st = rlwq_pkg::ST_NEST_SATURATED;
          n_saturated++;
        end else begin
          lock_depth++;
          st = rlwq_pkg::ST_NESTED_GRANT;
        end
      end else if (!lock_held) begin
        lock_held  = 1'b1;
        lock_owner = tid;
        lock_depth = 1;
        st = rlwq_pkg::ST_GRANTED;
      end else if (is_waiting[tid] || ring_count >= NUM_THREADS) begin
        st = rlwq_pkg::ST_ALREADY_WAITING;
      end else begin
        waiter_ring[(ring_head + ring_count) % NUM_THREADS] = tid;
        ring_count++;
        is_waiting[tid] = 1'b1;
        st = rlwq_pkg::ST_QUEUED;
      end
    end else begin
      if (!lock_held || lock_owner != tid) begin
        st = rlwq_pkg::ST_NOT_HOLDER;
      end else if (lock_depth > 1) begin
        lock_depth--;
        st = rlwq_pkg::ST_NESTED_RELEASE;
      end else if (ring_count > 0) begin
        // last release passes the lock straight to the oldest waiter
        woken = waiter_ring[ring_head];
        ring_head = (ring_head + 1) % NUM_THREADS;
        ring_count--;
        is_waiting[woken] = 1'b0;
        lock_owner = woken;
        lock_depth = 1;
        woke = 1'b1;
        st = rlwq_pkg::ST_HANDED_OFF;
        n_handoffs++;
      end else begin
        lock_held  = 1'b0;
        lock_owner = '0;
        lock_depth = 0;
        st = rlwq_pkg::ST_FREED;
      end
    end
    if (ring_count > n_peak) n_peak = ring_count;
    e.status       = st;
    e.woken_valid  = woke;
    e.woken_thread = woken;
    e.nest_count   = lock_held ? rlwq_pkg::NEST_O_W'(lock_depth) : '0;
    e.queue_length = rlwq_pkg::QLEN_W'(ring_count);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_lock();
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("[%0t] unexpected result item: status %0d woken %0b/%0d nest %0d qlen %0d",
                     $realtime, rsp.status, rsp.woken_valid, rsp.woken_thread,
                     rsp.nest_count, rsp.queue_length);
        end else begin
          want = expected_rsp_q.pop_front();
          n_checked++;
          if (rsp.status !== want.status || rsp.woken_valid !== want.woken_valid ||
              rsp.woken_thread !== want.woken_thread ||
              rsp.nest_count !== want.nest_count ||
              rsp.queue_length !== want.queue_length) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("[%0t] mismatch on result item %0d", $realtime, n_checked);
              $display("  expected: status %0d woken %0b/%0d nest %0d qlen %0d",
                       want.status, want.woken_valid, want.woken_thread,
                       want.nest_count, want.queue_length);
              $display("  actual:   status %0d woken %0b/%0d nest %0d qlen %0d",
                       rsp.status, rsp.woken_valid, rsp.woken_thread,
                       rsp.nest_count, rsp.queue_length);
            end
          end
        end
      end
      if (req_valid && !req_stall) begin
        resolve_request(req, predicted);
        expected_rsp_q.push_back(predicted);
      end
    end
    fail_count   <= n_fail;
    pending      <= expected_rsp_q.size();
    checked      <= n_checked;
    handoffs     <= n_handoffs;
    saturations  <= n_saturated;
    peak_waiters <= n_peak;
  end

endmodule

// File: verif/recursive_lock_with_wait_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recursive_lock_with_wait_queue_test
// Drives acquire and release items into the lock arbiter with random gaps and
// result stalls; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module recursive_lock_with_wait_queue_test;

  localparam int ITEM_TARGET = 2000;
  localparam int CALM_ITEMS  = 250;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_THREADS = rlwq_pkg::DEF_MAX_THREADS;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  rlwq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rlwq_pkg::rsp_t rsp;

  int fail_count;
  int pending;
  int checked;
  int handoffs;
  int saturations;
  int peak_waiters;

  int sent_count  = 0;
  int cycle_count = 0;
  int gap_odds    = 0;
  bit calm        = 1'b0;
  int tid_order [NUM_THREADS];

  recursive_lock_with_wait_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  recursive_lock_with_wait_queue_checker lock_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .handoffs     (handoffs),
    .saturations  (saturations),
    .peak_waiters (peak_waiters)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
      $display("FAIL recursive_lock_with_wait_queue");
      $finish;
    end
  end

  // result side stalls in bursts; odds change every window, some windows none
  initial begin
    int win_left;
    int odds;
    win_left = 0;
    odds     = 0;
    forever begin
      @(posedge clk);
      if (win_left == 0) begin
        win_left = 128;
        odds = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(2, 12);
      end
      win_left--;
      if (!calm && !rst && odds != 0 && $urandom_range(1, odds) == 1) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // presents one item and returns at the edge where it is taken
  task automatic send(input rlwq_pkg::op_t op, input int tid);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{opcode: op, thread_id: rlwq_pkg::TID_W'(tid)};
    do @(posedge clk); while (req_stall);
    sent_count++;
    calm = (sent_count >= ITEM_TARGET - CALM_ITEMS);
  endtask

  task automatic shuffle_threads();
    int j;
    int t;
    for (int i = 0; i < NUM_THREADS; i++) tid_order[i] = i;
    for (int i = NUM_THREADS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = tid_order[i];
      tid_order[i] = tid_order[j];
      tid_order[j] = t;
    end
  endtask

  // a few threads fighting over the lock
  task automatic contend();
    int pool [4];
    int n;
    n = $urandom_range(2, 4);
    for (int i = 0; i < 4; i++) pool[i] = $urandom_range(0, 15);
    repeat ($urandom_range(8, 40))
      send(($urandom_range(0, 99) < 55) ? rlwq_pkg::OP_ACQUIRE : rlwq_pkg::OP_RELEASE,
           pool[$urandom_range(0, n - 1)]);
  endtask

  // many threads line up, then each releases in arrival order
  task automatic crowd();
    int k;
    int reps [NUM_THREADS];
    shuffle_threads();
    k = ($urandom_range(0, 2) == 0) ? NUM_THREADS : $urandom_range(2, 15);
    for (int i = 0; i < k; i++) begin
      reps[i] = ($urandom_range(0, 3) == 0) ? 2 : 1;
      repeat (reps[i]) send(rlwq_pkg::OP_ACQUIRE, tid_order[i]);
    end
    for (int i = 0; i < k; i++)
      repeat (reps[i]) send(rlwq_pkg::OP_RELEASE, tid_order[i]);
  endtask

  // releases from everyone to unwind whatever is held
  task automatic drain();
    repeat ($urandom_range(2, 4)) begin
      shuffle_threads();
      for (int i = 0; i < NUM_THREADS; i++)
        repeat ($urandom_range(1, 3)) send(rlwq_pkg::OP_RELEASE, tid_order[i]);
    end
  endtask

  task automatic noise();
    repeat ($urandom_range(5, 20))
      send(rlwq_pkg::op_t'($urandom_range(0, 1)), $urandom_range(0, 15));
  endtask

  // holder nests up to the limit and past it while another thread waits
  task automatic nest_to_limit();
    int t;
    int w;
    int extra;
    int join_at;
    t = $urandom_range(0, 15);
    w = (t + $urandom_range(1, 15)) % NUM_THREADS;
    extra   = $urandom_range(1, 3);
    join_at = $urandom_range(1, 200);
    for (int i = 0; i < rlwq_pkg::DEF_MAX_NEST + extra; i++) begin
      send(rlwq_pkg::OP_ACQUIRE, t);
      if (i == join_at) send(rlwq_pkg::OP_ACQUIRE, w);
    end
    send(rlwq_pkg::OP_RELEASE, w);
    repeat (rlwq_pkg::DEF_MAX_NEST) send(rlwq_pkg::OP_RELEASE, t);
    send(rlwq_pkg::OP_RELEASE, w);
  endtask

  initial begin
    int pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk through every outcome but nest saturation, starting from a free lock
    send(rlwq_pkg::OP_ACQUIRE, 0);
    send(rlwq_pkg::OP_ACQUIRE, 0);
    send(rlwq_pkg::OP_ACQUIRE, 15);
    send(rlwq_pkg::OP_ACQUIRE, 15);
    send(rlwq_pkg::OP_ACQUIRE, 7);
    send(rlwq_pkg::OP_RELEASE, 15);
    send(rlwq_pkg::OP_RELEASE, 9);
    send(rlwq_pkg::OP_RELEASE, 0);
    send(rlwq_pkg::OP_RELEASE, 0);
    send(rlwq_pkg::OP_ACQUIRE, 15);
    send(rlwq_pkg::OP_RELEASE, 15);
    send(rlwq_pkg::OP_RELEASE, 15);
    send(rlwq_pkg::OP_RELEASE, 7);
    send(rlwq_pkg::OP_RELEASE, 7);
    send(rlwq_pkg::OP_RELEASE, 0);
    send(rlwq_pkg::OP_ACQUIRE, 15);
    send(rlwq_pkg::OP_RELEASE, 15);

    gap_odds = 6;
    nest_to_limit();

    while (sent_count < ITEM_TARGET) begin
      gap_odds = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(3, 10);
      pick = $urandom_range(0, 99);
      if (pick < 50)      contend();
      else if (pick < 75) crowd();
      else if (pick < 88) drain();
      else                noise();
    end
    req_valid <= 1'b0;

    // let the checker count the last accepted item before watching pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d requests and %0d checked results, %0d mismatches",
             sent_count, checked, fail_count);
    $display("lock handed off %0d times, nest limit hit %0d times, up to %0d waiters",
             handoffs, saturations, peak_waiters);
    if (fail_count == 0) begin
      $display("PASS recursive_lock_with_wait_queue");
    end else begin
      $display("FAIL recursive_lock_with_wait_queue");
    end
    $finish;
  end

endmodule
